>>> design/spcq_pkg.sv
`default_nettype none
package spcq_pkg;

   localparam int PRIO_W = 8;
   localparam int KIND_W = 8;
   localparam int PAYLOAD_W = 32;
   localparam int HELD_W = 5;
   localparam int DROPS_W = 32;
   localparam int CFG_W = 8;
   localparam int CFG_INDEX_W = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP = 1'b1;

   localparam logic [1:0] STATUS_PUSHED = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_POPPED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   localparam logic [CFG_INDEX_W-1:0] CFG_ESTOP_KIND = 2'd0;
   localparam logic [CFG_INDEX_W-1:0] CFG_CRITICAL_LEVEL = 2'd1;
   localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_LEVEL = 2'd2;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [KIND_W-1:0] kind;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic found;
      logic [PRIO_W-1:0] level;
      entry_type entry;
   } link_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ctrl_type;

   typedef struct packed {
      logic [CFG_W-1:0] estop_kind;
      logic [CFG_W-1:0] critical_level;
      logic [CFG_W-1:0] normal_level;
   } cfg_type;

endpackage
`default_nettype wire

>>> design/spcq_cell.sv
`default_nettype none
module spcq_cell #(
   parameter int QUEUE_DEPTH = 16,
   parameter int CELL_INDEX = 0
) (
   input wire logic clock,
   input wire spcq_pkg::ctrl_type ctrl_i,
   input wire spcq_pkg::cfg_type cfg_i,
   input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] count_i,
   input wire logic [$clog2(QUEUE_DEPTH)-1:0] best_idx_i,
   input wire spcq_pkg::entry_type push_entry_i,
   input wire spcq_pkg::entry_type next_entry_i,
   input wire spcq_pkg::link_type link_i,
   input wire logic [$clog2(QUEUE_DEPTH)-1:0] link_idx_i,
   output spcq_pkg::entry_type entry_o,
   output spcq_pkg::link_type link_o,
   output logic [$clog2(QUEUE_DEPTH)-1:0] link_idx_o
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   spcq_pkg::entry_type entry_ff, entry_in;
   spcq_pkg::link_type link_ff, link_in;
   logic [IDX_W-1:0] link_idx_ff, link_idx_in;
   logic [spcq_pkg::PRIO_W-1:0] level;
   logic occupied;
   logic take;

   // effective priority of the held entry
   always_comb begin
      if (entry_ff.prio != '0) begin
         level = entry_ff.prio;
      end else if (entry_ff.kind == cfg_i.estop_kind) begin
         level = cfg_i.critical_level;
      end else begin
         level = cfg_i.normal_level;
      end
   end

   assign occupied = CNT_W'(CELL_INDEX) < count_i;
   // strict compare keeps the oldest entry on ties
   assign take = occupied && (!link_i.found || (level > link_i.level));

   always_comb begin
      if (take) begin
         link_in.found = 1'b1;
         link_in.level = level;
         link_in.entry = entry_ff;
         link_idx_in = IDX_W'(CELL_INDEX);
      end else begin
         link_in = link_i;
         link_idx_in = link_idx_i;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl_i.push && (count_i == CNT_W'(CELL_INDEX))) begin
         entry_in = push_entry_i;
      end else if (ctrl_i.pop && (IDX_W'(CELL_INDEX) >= best_idx_i)) begin
         entry_in = next_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      link_ff <= link_in;
      link_idx_ff <= link_idx_in;
   end

   assign entry_o = entry_ff;
   assign link_o = link_ff;
   assign link_idx_o = link_idx_ff;

endmodule
`default_nettype wire

>>> design/stable_priority_command_queue.sv
`default_nettype none
// channel   direction  ports                                  transfer
// req       in         req_tvalid/tready, tuser, tdata         one command
// rsp       out        rsp_tvalid/tready, tuser, tdata         one result per command
// csr       in         csr_wr_en, csr_index, csr_wdata         register write, no wait
// a push goes from its transfer straight to the finish state, with no scan
// a pop on a non-empty queue scans the cell row one cell per cycle before finishing
// a new command is taken as soon as the last one finished, even if its result waits
// a result that is not taken holds completion of the following command
// reset empties the queue, clears the drop count and reloads the registers
module stable_priority_command_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [0:0] req_tuser,    // operation
   input wire logic [47:0] req_tdata,   // cmd_priority, cmd_kind, cmd_payload
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [1:0] rsp_tuser,        // status
   output logic [87:0] rsp_tdata,       // out_priority, out_kind, out_payload,
                                        // entries_held, drops_total, zero fill
   input wire logic csr_wr_en,
   input wire logic [spcq_pkg::CFG_INDEX_W-1:0] csr_index,
   input wire logic [spcq_pkg::CFG_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [spcq_pkg::DROPS_W-1:0] drops_ff, drops_in;
   spcq_pkg::cfg_type cfg_ff, cfg_in;
   logic op_ff, op_in;
   spcq_pkg::entry_type req_entry_ff, req_entry_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [87:0] rsp_data_ff, rsp_data_in;

   spcq_pkg::ctrl_type ctrl;
   spcq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   spcq_pkg::link_type link [QUEUE_DEPTH+1];
   logic [IDX_W-1:0] link_idx [QUEUE_DEPTH+1];
   spcq_pkg::entry_type taken;
   logic req_fire;
   logic finish;
   logic full;
   logic empty;
   logic [1:0] status;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign finish = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   assign ctrl.push = finish && (op_ff == spcq_pkg::OP_PUSH) && !full;
   assign ctrl.pop = finish && (op_ff == spcq_pkg::OP_POP) && !empty;

   assign link[0] = '0;
   assign link_idx[0] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spcq_pkg::entry_type next_entry;
      if (i == QUEUE_DEPTH-1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end
      spcq_cell #(
         .QUEUE_DEPTH(QUEUE_DEPTH),
         .CELL_INDEX(i)
      ) u_cell (
         .clock(clock),
         .ctrl_i(ctrl),
         .cfg_i(cfg_ff),
         .count_i(count_ff),
         .best_idx_i(link_idx[QUEUE_DEPTH]),
         .push_entry_i(req_entry_ff),
         .next_entry_i(next_entry),
         .link_i(link[i]),
         .link_idx_i(link_idx[i]),
         .entry_o(cell_entry[i]),
         .link_o(link[i+1]),
         .link_idx_o(link_idx[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      op_in = op_ff;
      req_entry_in = req_entry_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in = req_tuser[0];
               req_entry_in = spcq_pkg::entry_type'(req_tdata);
               scan_in = '0;
               if ((req_tuser[0] == spcq_pkg::OP_POP) && !empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IDX_W'(QUEUE_DEPTH-1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      drops_in = drops_ff;
      taken = '0;
      status = spcq_pkg::STATUS_PUSHED;
      if (op_ff == spcq_pkg::OP_PUSH) begin
         if (full) begin
            status = spcq_pkg::STATUS_DROPPED;
            if (finish) begin
               drops_in = drops_ff + 1'b1;
            end
         end else if (finish) begin
            count_in = count_ff + 1'b1;
         end
      end else if (empty) begin
         status = spcq_pkg::STATUS_EMPTY;
      end else begin
         status = spcq_pkg::STATUS_POPPED;
         taken = link[QUEUE_DEPTH].entry;
         if (finish) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = status;
         rsp_data_in = {3'b000, drops_in, spcq_pkg::HELD_W'(count_in),
                        taken.payload, taken.kind, taken.prio};
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            spcq_pkg::CFG_ESTOP_KIND: cfg_in.estop_kind = csr_wdata;
            spcq_pkg::CFG_CRITICAL_LEVEL: cfg_in.critical_level = csr_wdata;
            spcq_pkg::CFG_NORMAL_LEVEL: cfg_in.normal_level = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drops_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.estop_kind <= 8'd0;
         cfg_ff.critical_level <= 8'd255;
         cfg_ff.normal_level <= 8'd1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drops_ff <= drops_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      op_ff <= op_in;
      req_entry_ff <= req_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire

>>> tb/stable_priority_command_queue_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_command_queue_checker
   import spcq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic [0:0] req_tuser,    // operation
   input wire logic [47:0] req_tdata,   // cmd_priority, cmd_kind, cmd_payload
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [1:0] rsp_tuser,    // status
   input wire logic [87:0] rsp_tdata,   // out_priority, out_kind, out_payload,
                                        // entries_held, drops_total, zero fill
   input wire logic csr_wr_en,
   input wire logic [CFG_INDEX_W-1:0] csr_index,
   input wire logic [CFG_W-1:0] csr_wdata,
   output int fail_count,
   output int replies_owed
);

   typedef struct packed {
      logic [1:0] status;
      logic [PRIO_W-1:0] prio;
      logic [KIND_W-1:0] kind;
      logic [PAYLOAD_W-1:0] payload;
      logic [HELD_W-1:0] held;
      logic [DROPS_W-1:0] drops;
   } reply_type;

   entry_type held_entries[$];
   reply_type pending_replies[$];
   logic [DROPS_W-1:0] drop_tally;
   cfg_type levels;
   int fails;

   initial begin
      fails = 0;
      drop_tally = '0;
      fail_count = 0;
      replies_owed = 0;
   end

   function automatic logic [PRIO_W-1:0] urgency_of(entry_type e);
      if (e.prio != '0) begin
         return e.prio;
      end
      return (e.kind == levels.estop_kind) ? levels.critical_level : levels.normal_level;
   endfunction

   // one command against the queue copy: returns the reply the block owes
   function automatic reply_type serve_command(logic op, entry_type cmd);
      reply_type r;
      int best;
      logic [PRIO_W-1:0] best_level;
      r = '0;
      if (op == OP_PUSH) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            drop_tally = drop_tally + 1'b1;
            r.status = STATUS_DROPPED;
         end else begin
            held_entries.push_back(cmd);
            r.status = STATUS_PUSHED;
         end
      end else if (held_entries.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         best = 0;
         best_level = urgency_of(held_entries[0]);
         // strict compare keeps the oldest among equals
         for (int k = 1; k < held_entries.size(); k++) begin
            if (urgency_of(held_entries[k]) > best_level) begin
               best_level = urgency_of(held_entries[k]);
               best = k;
            end
         end
         r.prio = held_entries[best].prio;
         r.kind = held_entries[best].kind;
         r.payload = held_entries[best].payload;
         held_entries.delete(best);
         r.status = STATUS_POPPED;
      end
      r.held = HELD_W'(held_entries.size());
      r.drops = drop_tally;
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %h actual %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         held_entries.delete();
         pending_replies.delete();
         drop_tally = '0;
         levels.estop_kind = 8'h00;
         levels.critical_level = 8'hFF;
         levels.normal_level = 8'h01;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               $error("result transfer with no command waiting for one");
               fails++;
            end else begin
               want = pending_replies.pop_front();
               compare_field("status", want.status, rsp_tuser);
               compare_field("out_priority", want.prio, rsp_tdata[7:0]);
               compare_field("out_kind", want.kind, rsp_tdata[15:8]);
               compare_field("out_payload", want.payload, rsp_tdata[47:16]);
               compare_field("entries_held", want.held, rsp_tdata[52:48]);
               compare_field("drops_total", want.drops, rsp_tdata[84:53]);
               compare_field("zero_fill", '0, rsp_tdata[87:85]);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CFG_ESTOP_KIND: levels.estop_kind = csr_wdata;
               CFG_CRITICAL_LEVEL: levels.critical_level = csr_wdata;
               CFG_NORMAL_LEVEL: levels.normal_level = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pending_replies.push_back(serve_command(req_tuser[0], entry_type'(req_tdata)));
         end
      end
      replies_owed <= pending_replies.size();
      fail_count <= fails;
   end

endmodule
`default_nettype wire

>>> tb/stable_priority_command_queue_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_command_queue_tb;
   import spcq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 10;
   localparam int PHASE_ITEMS = 190;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [0:0] req_tuser;
   logic [47:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [1:0] rsp_tuser;
   logic [87:0] rsp_tdata;
   logic csr_wr_en;
   logic [CFG_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int fail_count;
   int replies_owed;
   bit steady;
   logic [KIND_W-1:0] estop_now;

   stable_priority_command_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   stable_priority_command_queue_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .replies_owed(replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // receiver readiness: ready runs broken by stalls
   initial begin
      int left;
      bit ready_on;
      left = 0;
      ready_on = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            if (ready_on) begin
               left = pick_gap();
               ready_on = (left == 0);
            end else begin
               ready_on = 1'b1;
            end
            if (left == 0) begin
               left = $urandom_range(1, 20);
            end
         end
         rsp_tready <= ready_on;
         left--;
      end
   end

   task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CFG_ESTOP_KIND) begin
         estop_now = val;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_cmd(logic op, logic [PRIO_W-1:0] prio, logic [KIND_W-1:0] kind,
                           logic [PAYLOAD_W-1:0] payload);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {payload, kind, prio};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   task automatic send_random(int push_pct);
      logic op;
      logic [PRIO_W-1:0] prio;
      logic [KIND_W-1:0] kind;
      int sel;
      op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      sel = $urandom_range(9);
      if (sel < 4) begin
         prio = '0;
      end else if (sel < 6) begin
         case ($urandom_range(2))
            0: prio = 8'd1;
            1: prio = 8'd128;
            default: prio = 8'd255;
         endcase
      end else begin
         prio = PRIO_W'($urandom_range(255));
      end
      kind = ($urandom_range(9) < 4) ? estop_now : KIND_W'($urandom_range(255));
      send_cmd(op, prio, kind, $urandom);
   endtask

   initial begin
      int push_pct[8];
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      steady = 1'b0;
      estop_now = 8'h00;
      push_pct = '{60, 40, 75, 50, 90, 30, 65, 55};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset register values
      send_cmd(OP_POP, 8'h00, 8'h00, 32'h0000_0000);
      send_cmd(OP_PUSH, 8'h00, 8'h00, 32'h0000_0000);
      send_cmd(OP_PUSH, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_cmd(OP_PUSH, 8'h00, 8'h5A, 32'hA5A5_A5A5);
      send_cmd(OP_PUSH, 8'h01, 8'h5A, 32'h5A5A_5A5A);
      send_cmd(OP_PUSH, 8'h80, 8'h01, 32'h8000_0001);
      send_cmd(OP_PUSH, 8'h00, 8'h00, 32'h1234_5678);
      for (int i = 0; i < 10; i++) begin
         send_cmd(OP_PUSH, 8'(i * 40), 8'(i * 29 + 1), $urandom);
      end
      send_cmd(OP_PUSH, 8'h7F, 8'h80, 32'hDEAD_BEEF);
      send_cmd(OP_PUSH, 8'h00, 8'h00, 32'hFFFF_0000);
      for (int i = 0; i < 6; i++) begin
         send_cmd(OP_POP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      end

      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            0: begin
               write_reg(CFG_ESTOP_KIND, 8'h00);
               write_reg(CFG_CRITICAL_LEVEL, 8'hFF);
               write_reg(CFG_NORMAL_LEVEL, 8'h01);
            end
            1: begin
               write_reg(CFG_ESTOP_KIND, 8'hFF);
               write_reg(CFG_CRITICAL_LEVEL, 8'h01);
               write_reg(CFG_NORMAL_LEVEL, 8'hFF);
            end
            2: begin
               write_reg(CFG_ESTOP_KIND, 8'h00);
               write_reg(CFG_CRITICAL_LEVEL, 8'h00);
               write_reg(CFG_NORMAL_LEVEL, 8'h00);
            end
            default: begin
               write_reg(CFG_ESTOP_KIND, CFG_W'($urandom_range(255)));
               write_reg(CFG_CRITICAL_LEVEL, CFG_W'($urandom_range(255)));
               write_reg(CFG_NORMAL_LEVEL, CFG_W'($urandom_range(255)));
            end
         endcase
         steady = (p == 3) || (p == 6);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random(push_pct[p]);
         end
      end

      drain();
      steady = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
